// ===== src/edssa_pkg.sv =====
// ----------------------------------------------------------------------------
// edssa_pkg
// Shared widths, operation codes and types of the elastic-degenerate
// Shift-And search block.
// ----------------------------------------------------------------------------
package edssa_pkg;

   localparam int ALPHABET_SIZE = 256;
   localparam int MAX_PATTERN   = 32;
   localparam int SYM_W         = 8;
   localparam int POS_W         = 5;
   localparam int OP_W          = 3;
   localparam int PLEN_W        = 6;
   localparam int CNT_W         = 32;

   // operation codes
   localparam logic [OP_W-1:0] OP_CLEAR      = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD       = 3'd1;
   localparam logic [OP_W-1:0] OP_TEXT       = 3'd2;
   localparam logic [OP_W-1:0] OP_ELEM_START = 3'd3;
   localparam logic [OP_W-1:0] OP_SYMBOL     = 3'd4;
   localparam logic [OP_W-1:0] OP_ELEM_END   = 3'd5;
   localparam logic [OP_W-1:0] OP_SEG_END    = 3'd6;

   typedef logic [MAX_PATTERN-1:0] vec_type;

   // one input item as held in the input register
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [SYM_W-1:0] symbol;
      logic [POS_W-1:0] position;
   } item_type;

   // pipeline strobes shared by the stages
   typedef struct packed {
      logic load;      // input register takes a new item
      logic advance;   // input register item moves to the result register
   } pipe_ctl_type;

endpackage

// ===== src/edssa_mask_store.sv =====
// ----------------------------------------------------------------------------
// edssa_mask_store
// Symbol mask table: 256 x 32 memory with per-entry valid bits for the
// one-item clear, read at accept time, read-modify-write for pattern loads
// and a one-entry bypass for a load directly followed by a read.
// ----------------------------------------------------------------------------
module edssa_mask_store (
   input  logic                        clock,
   input  logic                        reset,
   input  edssa_pkg::pipe_ctl_type     ctl,
   input  logic [edssa_pkg::SYM_W-1:0] rd_symbol,
   input  edssa_pkg::item_type         s1_item,
   output edssa_pkg::vec_type          mask
);
   import edssa_pkg::*;

   vec_type                  mem [ALPHABET_SIZE];
   vec_type                  rd_ff;
   logic [ALPHABET_SIZE-1:0] vld_ff, vld_in;
   logic                     byp_vld_ff, byp_vld_in;
   logic [SYM_W-1:0]         byp_addr_ff, byp_addr_in;
   vec_type                  byp_data_ff, byp_data_in;
   logic                     byp_hit;
   logic                     wr_en;
   vec_type                  wr_data;

   // effective mask of the item in the input register
   always_comb begin
      byp_hit = byp_vld_ff && (byp_addr_ff == s1_item.symbol);
      if (byp_hit) begin
         mask = byp_data_ff;
      end else if (vld_ff[s1_item.symbol]) begin
         mask = rd_ff;
      end else begin
         mask = '0;
      end
      wr_en   = ctl.advance && (s1_item.op == OP_LOAD);
      wr_data = mask | (vec_type'(1) << s1_item.position);
   end

   // valid bits: clear op drops all, a load marks its entry
   always_comb begin
      vld_in = vld_ff;
      if (ctl.advance && (s1_item.op == OP_CLEAR)) begin
         vld_in = '0;
      end else if (wr_en) begin
         vld_in[s1_item.symbol] = 1'b1;
      end
   end

   // bypass covers a write in the same cycle as the next read;
   // it lapses once the item that needed it has left
   always_comb begin
      byp_vld_in  = byp_vld_ff;
      byp_addr_in = byp_addr_ff;
      byp_data_in = byp_data_ff;
      if (ctl.load) begin
         byp_vld_in  = wr_en;
         byp_addr_in = s1_item.symbol;
         byp_data_in = wr_data;
      end else if (ctl.advance) begin
         byp_vld_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         byp_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         byp_vld_ff <= byp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      byp_addr_ff <= byp_addr_in;
      byp_data_ff <= byp_data_in;
   end

   // memory port: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[s1_item.symbol] <= wr_data;
      end
      if (ctl.load) begin
         rd_ff <= mem[rd_symbol];
      end
   end

   // a bypassed entry was written, so it must be marked valid
   a_byp_valid: assert property (@(posedge clock) disable iff (reset)
      byp_vld_ff |-> vld_ff[byp_addr_ff])
      else $error("bypass entry not valid");

   // clear op leaves no valid entry behind
   a_clear_all: assert property (@(posedge clock) disable iff (reset)
      (ctl.advance && s1_item.op == OP_CLEAR) |=> (vld_ff == '0))
      else $error("table clear incomplete");

   // a load always sets its own position bit
   a_load_bit: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_data[s1_item.position])
      else $error("load lost position bit");

endmodule

// ===== src/edssa_vector_unit.sv =====
// ----------------------------------------------------------------------------
// edssa_vector_unit
// Shift-And state: element, segment-start and merge vectors and the
// saturating match counter; produces the result fields of each item.
// ----------------------------------------------------------------------------
module edssa_vector_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  edssa_pkg::item_type          s1_item,
   input  edssa_pkg::vec_type           mask,
   input  logic [edssa_pkg::PLEN_W-1:0] plen,
   output logic                         hit,
   output logic [edssa_pkg::CNT_W-1:0]  match_count,
   output edssa_pkg::vec_type           active_bits
);
   import edssa_pkg::*;

   vec_type              ev_ff, ev_in;
   vec_type              ss_ff, ss_in;
   vec_type              sm_ff, sm_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   vec_type              ev_step;
   logic                 plen_ok;
   logic [POS_W-1:0]     plen_m1;

   // next state per operation
   always_comb begin
      ev_step = ((ev_ff << 1) | vec_type'(1)) & mask;
      plen_ok = (plen != '0) && (plen <= PLEN_W'(MAX_PATTERN));
      plen_m1 = POS_W'(plen - PLEN_W'(1));
      ev_in   = ev_ff;
      ss_in   = ss_ff;
      sm_in   = sm_ff;
      cnt_in  = cnt_ff;
      hit     = 1'b0;
      case (s1_item.op)
         OP_TEXT: begin
            ev_in  = '0;
            ss_in  = '0;
            sm_in  = '0;
            cnt_in = '0;
         end
         OP_ELEM_START: begin
            ev_in = ss_ff;
         end
         OP_SYMBOL: begin
            ev_in = ev_step;
            hit   = plen_ok && ev_step[plen_m1];
            if (hit && (cnt_ff != '1)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         OP_ELEM_END: begin
            sm_in = sm_ff | ev_ff;
         end
         OP_SEG_END: begin
            ss_in = sm_ff;
            sm_in = '0;
         end
         default: begin
         end
      endcase
      match_count = cnt_in;
      active_bits = ev_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff  <= '0;
         ss_ff  <= '0;
         sm_ff  <= '0;
         cnt_ff <= '0;
      end else if (advance) begin
         ev_ff  <= ev_in;
         ss_ff  <= ss_in;
         sm_ff  <= sm_in;
         cnt_ff <= cnt_in;
      end
   end

   // counter moves only on a hit or a text start
   a_cnt_move: assert property (@(posedge clock) disable iff (reset)
      (advance && !hit && s1_item.op != OP_TEXT) |=> $stable(cnt_ff))
      else $error("counter changed without hit");

   // a text start empties every vector
   a_text_clear: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_item.op == OP_TEXT) |=> (ev_ff == '0 && ss_ff == '0 && sm_ff == '0))
      else $error("text start left state");

endmodule

// ===== src/eds_shift_and_search.sv =====
// ----------------------------------------------------------------------------
// eds_shift_and_search
// Shift-And exact matching over an elastic-degenerate text.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries operations (table clear, pattern load, text start, element
//   start, text symbol, element end, segment end); every transfer yields
//   exactly one rsp_* transfer with the hit flag, the saturating match count
//   and the element vector after the operation.
//   csr_we/csr_wdata set the pattern length (reset value 1); write it only
//   while no operation is in flight.
//   A request enters the input register at its transfer edge and moves on to
//   the result register when that register is free; rsp_tvalid rises once
//   the result register holds it. Throughput: one operation per cycle while
//   rsp_tready stays high, set by the single mask table read port and the vector update.
//   Reset clears the vectors, counter, table valid bits and pipeline.
//   When rsp_tready is low, the result register holds and one more item
//   waits in the input register; req_tready then drops until rsp drains.
// ----------------------------------------------------------------------------
module eds_shift_and_search (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata,   // pattern_length
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] symbol, [12:8] position
   input  logic [2:0]  req_tuser,   // [2:0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] match_count, [63:32] active_bits
   output logic        rsp_tuser    // [0] hit
);
   import edssa_pkg::*;

   pipe_ctl_type        ctl;
   item_type            req_item;
   item_type            s1_item_ff, s1_item_in;
   logic                s1_vld_ff, s1_vld_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   vec_type             rsp_bits_ff, rsp_bits_in;
   logic [PLEN_W-1:0]   plen_ff, plen_in;
   vec_type             mask;

   // unpack request
   assign req_item.op       = req_tuser;
   assign req_item.symbol   = req_tdata[7:0];
   assign req_item.position = req_tdata[12:8];

   // pipeline control
   always_comb begin
      ctl.advance = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
      req_tready  = !s1_vld_ff || ctl.advance;
      ctl.load    = req_tvalid && req_tready;
      s1_vld_in   = ctl.load ? 1'b1 : (ctl.advance ? 1'b0 : s1_vld_ff);
      s1_item_in  = ctl.load ? req_item : s1_item_ff;
      rsp_vld_in  = ctl.advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
      plen_in     = csr_we ? csr_wdata : plen_ff;
   end

   edssa_mask_store u_mask_store (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .rd_symbol (req_item.symbol),
      .s1_item   (s1_item_ff),
      .mask      (mask)
   );

   edssa_vector_unit u_vector_unit (
      .clock       (clock),
      .reset       (reset),
      .advance     (ctl.advance),
      .s1_item     (s1_item_ff),
      .mask        (mask),
      .plen        (plen_ff),
      .hit         (rsp_hit_in),
      .match_count (rsp_cnt_in),
      .active_bits (rsp_bits_in)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         plen_ff    <= PLEN_W'(1);
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         plen_ff    <= plen_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      if (ctl.advance) begin
         rsp_hit_ff  <= rsp_hit_in;
         rsp_cnt_ff  <= rsp_cnt_in;
         rsp_bits_ff <= rsp_bits_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {32'(rsp_bits_ff), rsp_cnt_ff};

   // an advancing item always shows up as a result
   a_adv_result: assert property (@(posedge clock) disable iff (reset)
      ctl.advance |=> rsp_vld_ff)
      else $error("advanced item lost");

   // input side stalls only behind a full, stalled output
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_vld_ff && rsp_vld_ff && !rsp_tready))
      else $error("spurious input stall");

   // a reported hit has been counted
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_hit_ff) |-> (rsp_cnt_ff != '0))
      else $error("hit with zero count");

endmodule

// ===== bench/eds_shift_and_search_checker.sv =====
// ----------------------------------------------------------------------------
// eds_shift_and_search_checker
// Watches the request, result and CSR ports of the Shift-And search block,
// keeps its own copy of the mask table, the element/segment vectors, the
// match counter and the pattern length, predicts one result per request
// transfer and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module eds_shift_and_search_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [5:0]  csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic [2:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int unsigned fault_count,
   output int unsigned results_due,
   output int unsigned results_checked,
   output int unsigned hits_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import edssa_pkg::*;

   typedef struct packed {
      logic             hit;
      logic [CNT_W-1:0] match_count;
      vec_type          active_bits;
   } search_result_type;

   // shadow of the search state
   vec_type             sym_mask [ALPHABET_SIZE];
   vec_type             elem_vec;
   vec_type             seg_start_vec;
   vec_type             seg_merge_vec;
   logic [CNT_W-1:0]    occ_count;
   logic [PLEN_W-1:0]   match_len;

   search_result_type   expected_q [$];
   int unsigned         n_faults;
   int unsigned         n_checked;
   int unsigned         n_hits;

   initial begin
      n_faults  = 0;
      n_checked = 0;
      n_hits    = 0;
   end

   // Apply one operation to the shadow state and return the result it yields
   function automatic search_result_type search_step(item_type it);
      search_result_type res;
      int                s;
      logic              found;
      found = 1'b0;
      case (it.op)
         OP_CLEAR: begin
            for (s = 0; s < ALPHABET_SIZE; s++) sym_mask[s] = '0;
         end
         OP_LOAD: begin
            sym_mask[it.symbol][it.position] = 1'b1;
         end
         OP_TEXT: begin
            elem_vec      = '0;
            seg_start_vec = '0;
            seg_merge_vec = '0;
            occ_count     = '0;
         end
         OP_ELEM_START: begin
            elem_vec = seg_start_vec;
         end
         OP_SYMBOL: begin
            // shift in a one, top bit drops out
            elem_vec = {elem_vec[MAX_PATTERN-2:0], 1'b1} & sym_mask[it.symbol];
            if (match_len >= 1 && match_len <= MAX_PATTERN) begin
               if (elem_vec[int'(match_len) - 1]) begin
                  found = 1'b1;
                  if (occ_count != '1) occ_count++;
               end
            end
         end
         OP_ELEM_END: begin
            seg_merge_vec |= elem_vec;
         end
         OP_SEG_END: begin
            seg_start_vec = seg_merge_vec;
            seg_merge_vec = '0;
         end
         default: begin
         end
      endcase
      res.hit         = found;
      res.match_count = occ_count;
      res.active_bits = elem_vec;
      return res;
   endfunction

   task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      n_faults++;
   endtask

   // Sample both channels and the CSR port at every rising edge
   always @(posedge clock) begin : monitor
      item_type          it;
      search_result_type want;
      search_result_type got;
      int                s;
      if (reset) begin
         for (s = 0; s < ALPHABET_SIZE; s++) sym_mask[s] = '0;
         elem_vec      = '0;
         seg_start_vec = '0;
         seg_merge_vec = '0;
         occ_count     = '0;
         match_len     = PLEN_W'(1);
         expected_q.delete();
      end else begin
         if (csr_we) match_len = csr_wdata;

         // result transfer: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.hit         = rsp_tuser;
            got.match_count = rsp_tdata[31:0];
            got.active_bits = rsp_tdata[63:32];
            if (expected_q.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual %h",
                        $time, got);
               n_faults++;
            end else begin
               want = expected_q.pop_front();
               n_checked++;
               if (got.hit !== want.hit)
                  report_field("hit", 32'(want.hit), 32'(got.hit));
               if (got.match_count !== want.match_count)
                  report_field("match_count", want.match_count, got.match_count);
               if (got.active_bits !== want.active_bits)
                  report_field("active_bits", want.active_bits, got.active_bits);
            end
         end

         // request transfer: predict its result
         if (req_tvalid && req_tready) begin
            it.op       = req_tuser;
            it.symbol   = req_tdata[7:0];
            it.position = req_tdata[12:8];
            want = search_step(it);
            if (want.hit) n_hits++;
            expected_q.push_back(want);
         end
      end
      fault_count     <= n_faults;
      results_due     <= expected_q.size();
      results_checked <= n_checked;
      hits_seen       <= n_hits;
   end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the elastic-degenerate Shift-And search block: a short
// directed sequence, then randomized pattern loads and segmented texts under
// a series of pattern lengths, with random gaps on requests and random
// backpressure on results. Checking is done by the checker instance.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import edssa_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
   localparam int unsigned     PHASE_ITEMS = 185;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [5:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;     // [7:0] symbol, [12:8] position
   logic [2:0]  req_tuser;     // [2:0] op
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;     // [31:0] match_count, [63:32] active_bits
   logic        rsp_tuser;     // [0] hit

   int unsigned fault_count;
   int unsigned results_due;
   int unsigned results_checked;
   int unsigned hits_seen;

   int unsigned       items_sent = 0;
   int unsigned       req_mode   = 0;
   int unsigned       n_lengths  = 0;
   logic [PLEN_W-1:0] cur_len    = PLEN_W'(1);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   eds_shift_and_search u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   eds_shift_and_search_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fault_count     (fault_count),
      .results_due     (results_due),
      .results_checked (results_checked),
      .hits_seen       (hits_seen)
   );

   // idle cycles before one transfer: none, occasional, or always random
   function automatic int unsigned idle_cycles(int unsigned mode);
      if (mode == 0) return 0;
      if (mode == 1) return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      return $urandom_range(0, 18);
   endfunction

   function automatic item_type op_item(logic [OP_W-1:0] op, logic [SYM_W-1:0] sym,
                                        logic [POS_W-1:0] pos);
      item_type it;
      it.op       = op;
      it.symbol   = sym;
      it.position = pos;
      return it;
   endfunction

   // one request transfer, with an optional gap in front of it
   task automatic send(item_type it);
      int unsigned gap;
      if (items_sent % 64 == 0) req_mode = $urandom_range(0, 2);
      gap = idle_cycles(req_mode);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.op;
      req_tdata  <= {3'b000, it.position, it.symbol};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   // wait for the block to drain, then write the pattern length
   task automatic set_length(logic [PLEN_W-1:0] len);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= len;
      @(posedge clock);
      csr_we    <= 1'b0;
      cur_len = len;
      n_lengths++;
   endtask

   // pattern load followed by a segmented text over a small alphabet
   task automatic search_job();
      logic [SYM_W-1:0] base;
      logic [SYM_W-1:0] sym;
      int unsigned      plen, spread, segs, elems, elen;
      if (cur_len >= 1 && cur_len <= MAX_PATTERN) plen = cur_len;
      else plen = $urandom_range(1, 8);
      spread = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, 4);
      base   = SYM_W'($urandom_range(0, 255));
      // sometimes keep the old table so stale masks leak into the search
      if ($urandom_range(0, 4) != 0) send(op_item(OP_CLEAR, '0, '0));
      for (int unsigned p = 0; p < plen; p++) begin
         sym = base + SYM_W'($urandom_range(0, spread - 1));
         send(op_item(OP_LOAD, sym, POS_W'(p)));
      end
      if ($urandom_range(0, 3) == 0)
         send(op_item(OP_LOAD, base + SYM_W'($urandom_range(0, 3)),
                      POS_W'($urandom_range(0, 31))));
      send(op_item(OP_TEXT, SYM_W'($urandom_range(0, 255)), POS_W'($urandom_range(0, 31))));
      segs = $urandom_range(1, 4);
      for (int unsigned sg = 0; sg < segs; sg++) begin
         elems = $urandom_range(1, 3);
         for (int unsigned el = 0; el < elems; el++) begin
            send(op_item(OP_ELEM_START, '0, '0));
            elen = ($urandom_range(0, 3) == 0) ? $urandom_range(plen, plen + 8)
                                               : $urandom_range(0, 10);
            for (int unsigned k = 0; k < elen; k++) begin
               if ($urandom_range(0, 15) == 0) sym = SYM_W'($urandom_range(0, 255));
               else sym = base + SYM_W'($urandom_range(0, spread - 1));
               send(op_item(OP_SYMBOL, sym, POS_W'($urandom_range(0, 31))));
            end
            send(op_item(OP_ELEM_END, '0, '0));
         end
         send(op_item(OP_SEG_END, '0, '0));
      end
   endtask

   // random operations with random fields, including the unused code
   task automatic noise_burst();
      int unsigned n;
      n = $urandom_range(1, 6);
      repeat (n)
         send(op_item(OP_W'($urandom_range(0, 7)), SYM_W'($urandom_range(0, 255)),
                      POS_W'($urandom_range(0, 31))));
   endtask

   task automatic random_traffic(int unsigned quota);
      int unsigned start;
      start = items_sent;
      while (items_sent - start < quota) begin
         if ($urandom_range(0, 9) < 7) search_job();
         else noise_burst();
      end
   endtask

   // result side backpressure
   initial begin : rsp_side
      int unsigned stall;
      int unsigned served;
      int unsigned rsp_mode;
      served   = 0;
      rsp_mode = 0;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (served % 64 == 0) rsp_mode = $urandom_range(0, 2);
         stall = idle_cycles(rsp_mode);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         served++;
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      logic [PLEN_W-1:0] lengths [8];
      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_wdata  <= '0;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset pattern length, table extremes, every operation
      send(op_item(OP_CLEAR, 8'h00, 5'd0));
      send(op_item(OP_LOAD, 8'h00, 5'd0));
      send(op_item(OP_LOAD, 8'hFF, 5'd31));
      send(op_item(OP_LOAD, 8'hFF, 5'd1));
      send(op_item(OP_LOAD, 8'h5A, 5'd0));
      send(op_item(OP_TEXT, 8'h00, 5'd0));
      send(op_item(OP_ELEM_START, 8'h00, 5'd0));
      send(op_item(OP_SYMBOL, 8'h00, 5'd0));
      send(op_item(OP_SYMBOL, 8'hFF, 5'd31));
      send(op_item(OP_SYMBOL, 8'h81, 5'd0));     // never loaded: empty mask
      send(op_item(OP_ELEM_END, 8'h00, 5'd0));
      send(op_item(OP_ELEM_START, 8'h00, 5'd0));
      send(op_item(OP_SYMBOL, 8'h5A, 5'd0));
      send(op_item(OP_ELEM_END, 8'h00, 5'd0));
      send(op_item(OP_SEG_END, 8'h00, 5'd0));
      send(op_item(OP_ELEM_START, 8'h00, 5'd0));
      send(op_item(OP_UNUSED, 8'hFF, 5'd31));
      send(op_item(OP_SYMBOL, 8'hFF, 5'd0));
      send(op_item(OP_ELEM_END, 8'h00, 5'd0));
      send(op_item(OP_SEG_END, 8'h00, 5'd0));
      // new text keeps the table
      send(op_item(OP_TEXT, 8'hFF, 5'd31));
      send(op_item(OP_ELEM_START, 8'h00, 5'd0));
      send(op_item(OP_SYMBOL, 8'h00, 5'd0));
      send(op_item(OP_UNUSED, 8'h00, 5'd0));

      // random phases: full length, out of range (no match bit), short, and random lengths
      lengths[0] = 6'd32;
      lengths[1] = 6'd0;
      lengths[2] = 6'd3;
      lengths[3] = 6'd63;
      lengths[4] = 6'd1;
      lengths[5] = 6'd33;
      lengths[6] = PLEN_W'($urandom_range(2, 31));
      lengths[7] = PLEN_W'($urandom_range(2, 31));
      for (int ph = 0; ph < 8; ph++) begin
         set_length(lengths[ph]);
         random_traffic(PHASE_ITEMS);
      end

      // drain
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("%0d requests over %0d pattern lengths; %0d results checked, %0d hits",
               items_sent, n_lengths, results_checked, hits_seen);
      if (fault_count == 0) begin
         $display("[eds_shift_and_search] OK");
      end else begin
         $display("%0d mismatches", fault_count);
         $display("[eds_shift_and_search] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #10_000_000;
      $display("run timed out");
      $display("[eds_shift_and_search] ERROR");
      $finish;
   end

endmodule
